FILE: hw/rtl/ptbn_pkg.sv
// shared types and codes for the point table with bounding box and nearest search
// no dependencies
package ptbn_pkg;

  localparam int RAD_BITS = 24;
  localparam int OP_BITS  = 2;
  localparam int ST_BITS  = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 2'd0,
    OP_REM = 2'd1,
    OP_QRY = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_pass;
    logic scan_last;
    logic pipe_busy;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/ptbn_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module ptbn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ptbn_ctrl.sv
// controller state machine: sequences add, remove and query passes
// depends on ptbn_pkg
module ptbn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ptbn_pkg::sts_t sts,
  output ptbn_pkg::cmd_t cmd
);

  ptbn_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptbn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptbn_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ptbn_pkg::S_CHECK;
      end
      ptbn_pkg::S_CHECK: begin
        state_nxt = sts.need_pass ? ptbn_pkg::S_SCAN : ptbn_pkg::S_FINISH;
      end
      ptbn_pkg::S_SCAN: begin
        if (sts.scan_last) state_nxt = ptbn_pkg::S_DRAIN;
      end
      ptbn_pkg::S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ptbn_pkg::S_FINISH;
      end
      ptbn_pkg::S_FINISH: begin
        if (!sts.out_busy) state_nxt = ptbn_pkg::S_IDLE;
      end
      default: state_nxt = ptbn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ptbn_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ptbn_pkg::S_CHECK:  cmd.start  = 1'b1;
      ptbn_pkg::S_SCAN:   cmd.scan   = 1'b1;
      ptbn_pkg::S_DRAIN:  cmd        = '0;
      ptbn_pkg::S_FINISH: cmd.finish = !sts.out_busy;
      default:            cmd        = '0;
    endcase
  end

endmodule

FILE: hw/rtl/ptbn_dp.sv
// datapath: point store, extremes, shift and rescan pass, distance pipeline, output register
// depends on ptbn_pkg and ptbn_ram
module ptbn_dp #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24,
  localparam int IW    = $clog2(MAX_POINTS),
  localparam int CW    = $clog2(MAX_POINTS + 1),
  localparam int IN_W  = ((2 + 2*COORD_BITS + 24 + IW + 7) / 8) * 8,
  localparam int OUT_W = ((3 + 5*IW + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptbn_pkg::cmd_t   cmd,
  output ptbn_pkg::sts_t   sts,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  localparam int C     = COORD_BITS;
  localparam int RB    = ptbn_pkg::RAD_BITS;
  localparam int SQW   = 2*C + 2;
  localparam int D2W   = (2*C + 3 > 2*RB) ? 2*C + 3 : 2*RB;
  localparam int X_LO  = ptbn_pkg::OP_BITS;
  localparam int Y_LO  = X_LO + C;
  localparam int R_LO  = Y_LO + C;
  localparam int P_LO  = R_LO + RB;
  localparam int RAW_W = 3 + 5*IW + CW;

  ptbn_pkg::op_t op_r;
  logic [C-1:0]  cx_r, cy_r;
  logic [RB-1:0] rad_r;
  logic [IW-1:0] pidx_r;

  logic [CW-1:0] count_r, count_n;
  logic [IW-1:0] ext_r [4];
  logic [IW-1:0] ext_n [4];
  logic [C-1:0]  extv_r [4];
  logic [C-1:0]  extv_n [4];
  logic [IW-1:0] si_r [4];
  logic [IW-1:0] si_nxt [4];
  logic [C-1:0]  sv_r [4];
  logic [C-1:0]  sv_nxt [4];

  logic [IW-1:0]  j_r;
  logic           p1_v_r, p2_v_r, p3_v_r;
  logic [IW-1:0]  p1_j_r, p2_j_r, p3_j_r;
  logic [C:0]     ax_r, ay_r;
  logic [SQW-1:0] sqx_r, sqy_r;
  logic [D2W-1:0] best_r;
  logic           hit_r;
  logic [IW-1:0]  found_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic               we;
  logic [IW-1:0]      waddr;
  logic [2*C-1:0]     wdata, rdata;
  logic [C-1:0]       rx, ry;
  logic [IW-1:0]      ni;
  logic signed [C:0]  dx, dy;
  logic [D2W-1:0]     d2;
  logic [2*RB-1:0]    rsq;
  ptbn_pkg::status_t  status_n;
  logic [IW-1:0]      found_n;
  logic [RAW_W-1:0]   raw;

  ptbn_ram #(.WIDTH(2*C), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (j_r),
    .rdata (rdata)
  );

  assign rx = rdata[C-1:0];
  assign ry = rdata[2*C-1:C];
  assign ni = (p1_j_r > pidx_r) ? p1_j_r - 1'b1 : p1_j_r;

  assign sts.need_pass = ((op_r == ptbn_pkg::OP_REM) && (CW'(pidx_r) < count_r)) ||
                         ((op_r == ptbn_pkg::OP_QRY) && (count_r != '0));
  assign sts.scan_last = (CW'(j_r) == count_r - 1'b1);
  assign sts.pipe_busy = p1_v_r || p2_v_r || p3_v_r;
  assign sts.out_busy  = out_valid_r;

  // shift write and rescan on remove, point write on add
  always_comb begin
    logic [C-1:0] v;
    logic         better;
    we     = 1'b0;
    waddr  = ni;
    wdata  = rdata;
    sv_nxt = sv_r;
    si_nxt = si_r;
    v      = '0;
    better = 1'b0;
    if (p1_v_r && op_r == ptbn_pkg::OP_REM && p1_j_r != pidx_r) begin
      we = (p1_j_r > pidx_r);
      for (int k = 0; k < 4; k++) begin
        v = (k < 2) ? rx : ry;
        better = (k % 2 == 1) ? ($signed(v) > $signed(sv_r[k]))
                              : ($signed(v) < $signed(sv_r[k]));
        if (ni == '0 || better) begin
          sv_nxt[k] = v;
          si_nxt[k] = ni;
        end
      end
    end
    if (cmd.finish && op_r == ptbn_pkg::OP_ADD && count_r != CW'(MAX_POINTS)) begin
      we    = 1'b1;
      waddr = count_r[IW-1:0];
      wdata = {cy_r, cx_r};
    end
  end

  assign dx  = $signed({cx_r[C-1], cx_r}) - $signed({rx[C-1], rx});
  assign dy  = $signed({cy_r[C-1], cy_r}) - $signed({ry[C-1], ry});
  assign d2  = D2W'(sqx_r) + D2W'(sqy_r);
  assign rsq = (2*RB)'(rad_r) * (2*RB)'(rad_r);

  // end of operation update
  always_comb begin
    logic [C-1:0] v;
    count_n  = count_r;
    ext_n    = ext_r;
    extv_n   = extv_r;
    status_n = ptbn_pkg::ST_OK;
    found_n  = '0;
    v        = '0;
    unique case (op_r)
      ptbn_pkg::OP_ADD: begin
        if (count_r == CW'(MAX_POINTS)) begin
          status_n = ptbn_pkg::ST_FULL;
        end else begin
          count_n = count_r + 1'b1;
          for (int k = 0; k < 4; k++) begin
            v = (k < 2) ? cx_r : cy_r;
            if (count_r == '0) begin
              ext_n[k]  = '0;
              extv_n[k] = v;
            end else if ((k % 2 == 1) ? ($signed(v) > $signed(extv_r[k]))
                                      : ($signed(v) < $signed(extv_r[k]))) begin
              ext_n[k]  = count_r[IW-1:0];
              extv_n[k] = v;
            end
          end
        end
      end
      ptbn_pkg::OP_REM: begin
        if (CW'(pidx_r) >= count_r) begin
          status_n = ptbn_pkg::ST_RANGE;
        end else begin
          count_n = count_r - 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (count_n == '0) begin
              ext_n[k] = '0;
            end else if (ext_r[k] == pidx_r) begin
              ext_n[k]  = si_r[k];
              extv_n[k] = sv_r[k];
            end else if (ext_r[k] > pidx_r) begin
              ext_n[k] = ext_r[k] - 1'b1;
            end
          end
        end
      end
      ptbn_pkg::OP_QRY: begin
        if (hit_r) begin
          found_n = found_r;
        end else begin
          status_n = ptbn_pkg::ST_NONE;
        end
      end
      ptbn_pkg::OP_NOP: status_n = ptbn_pkg::ST_OK;
      default:          status_n = ptbn_pkg::ST_OK;
    endcase
  end

  assign raw = {ext_n[3], ext_n[2], ext_n[1], ext_n[0], (count_n != '0),
                count_n, found_n, status_n};

  // captured word and pass state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= ptbn_pkg::op_t'(in_data[ptbn_pkg::OP_BITS-1:0]);
      cx_r   <= in_data[X_LO +: C];
      cy_r   <= in_data[Y_LO +: C];
      rad_r  <= in_data[R_LO +: RB];
      pidx_r <= in_data[P_LO +: IW];
    end
    if (cmd.start) begin
      j_r     <= '0;
      best_r  <= D2W'(rsq);
      found_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.scan) j_r <= j_r + 1'b1;
      if (p3_v_r && d2 < best_r) begin
        best_r  <= d2;
        found_r <= p3_j_r;
        hit_r   <= 1'b1;
      end
    end
    sv_r   <= sv_nxt;
    si_r   <= si_nxt;
    p1_j_r <= j_r;
    p2_j_r <= p1_j_r;
    p3_j_r <= p2_j_r;
    ax_r   <= dx[C] ? (C+1)'(-dx) : dx;
    ay_r   <= dy[C] ? (C+1)'(-dy) : dy;
    sqx_r  <= SQW'(ax_r) * SQW'(ax_r);
    sqy_r  <= SQW'(ay_r) * SQW'(ay_r);
    if (cmd.finish) begin
      extv_r     <= extv_n;
      out_data_r <= OUT_W'(raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ext_r       <= '{default: '0};
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.scan;
      p2_v_r <= p1_v_r && (op_r == ptbn_pkg::OP_QRY);
      p3_v_r <= p2_v_r;
      if (cmd.finish) begin
        count_r     <= count_n;
        ext_r       <= ext_n;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/point_table_bbox_nearest.sv
// top level of the point table with bounding box and nearest search
// depends on ptbn_pkg, ptbn_ctrl, ptbn_dp and ptbn_ram
//
// channel   dir   fields
// in_*      in    opcode, coord_x, coord_y, radius, point_index
// out_*     out   op_status, found_index, point_count, bbox_valid, 4 extreme indices
//
// add, unused op, out of range remove and empty query go straight to the result; remove
// and query first scan the stored points, one store entry read per cycle
// reset clears count and extremes, store contents stay undefined until written
// a new word is taken while a result waits; the next result is held back
// until the output register is free
module point_table_bbox_nearest #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24,
  localparam int IW    = $clog2(MAX_POINTS),
  localparam int CW    = $clog2(MAX_POINTS + 1),
  localparam int IN_W  = ((2 + 2*COORD_BITS + 24 + IW + 7) / 8) * 8,
  localparam int OUT_W = ((3 + 5*IW + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // opcode, coord_x, coord_y, radius, point_index
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // op_status, found_index, point_count, bbox_valid,
  // min_x_index, max_x_index, min_y_index, max_y_index
  output logic [OUT_W-1:0] out_tdata
);

  ptbn_pkg::cmd_t cmd;
  ptbn_pkg::sts_t sts;

  ptbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptbn_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
